[sv/gpg_pkg.sv]
// ----------------------------------------------------------------------------
// gpg_pkg: shared types, constants and the sine table of the gait phase generator.
// Holds the payload types of both channels, the configuration register set,
// the fixed limits of the motion test and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package gpg_pkg;

	// Quarter-wave sine table size (entries per quarter cycle).
	localparam int SINE_TABLE_ENTRIES = 256;
	localparam int SINE_FOUR_N        = 4 * SINE_TABLE_ENTRIES;
	localparam int SINE_IDX_W         = $clog2(SINE_FOUR_N);
	localparam int SINE_R_W           = $clog2(SINE_TABLE_ENTRIES);
	localparam int SINE_TBL_W         = $clog2(SINE_TABLE_ENTRIES + 1);
	localparam int SINE_PROD_W        = 16 + SINE_IDX_W;

	// Command arithmetic widths and limits.
	localparam int AXIS_MAG_W = 15;
	localparam int VEL_W      = 30;
	localparam int SQ_W       = 2 * VEL_W;
	localparam logic [SQ_W-1:0]  VEL_SQ_LIMIT    = SQ_W'(64'd180143985094819);
	localparam logic [VEL_W-1:0] WZ_LIMIT        = VEL_W'(32'd13421772);
	localparam logic [15:0]      MID_CYCLE_LIMIT = 16'd3276;
	localparam logic [14:0]      HOLD_RELOAD     = 15'd16384;

	// Depth of the queue between the command front end and the phase back end.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Constants of the table construction, Q30 fixed point.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned Q30_HALF    = 64'd536870912;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_VX_MIN     = 3'd0,
		CFG_VX_MAX     = 3'd1,
		CFG_VY_MIN     = 3'd2,
		CFG_VY_MAX     = 3'd3,
		CFG_WZ_MIN     = 3'd4,
		CFG_WZ_MAX     = 3'd5,
		CFG_PHASE_STEP = 3'd6,
		CFG_HOLD_STEP  = 3'd7
	} cfg_idx_e;

	typedef struct packed {
		logic signed [15:0] vx_min;
		logic signed [15:0] vx_max;
		logic signed [15:0] vy_min;
		logic signed [15:0] vy_max;
		logic signed [15:0] wz_min;
		logic signed [15:0] wz_max;
		logic [15:0]        phase_step;
		logic [14:0]        hold_step;
	} cfg_t;

	// Payload of one control tick.
	typedef struct packed {
		logic               episode_start;
		logic               stick_present;
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] right_x;
	} cmd_t;

	// Payload of one result.
	typedef struct packed {
		logic [15:0]        phase;
		logic signed [15:0] sine_leg0;
		logic signed [15:0] sine_leg1;
		logic signed [15:0] sine_leg2;
		logic signed [15:0] sine_leg3;
	} gait_t;

	// Classified tick handed from the front end to the back end.
	typedef struct packed {
		logic episode_start;
		logic moving;
	} q_entry_t;

	typedef logic [14:0] sine_tab_t [0:SINE_TABLE_ENTRIES];

	// Builds the quarter-wave table by a Taylor series in Q30 fixed point.
	function automatic sine_tab_t build_sine();
		sine_tab_t         tab;
		longint unsigned   x;
		longint unsigned   term;
		longint unsigned   sum;
		longint unsigned   e;
		for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
			x = (HALF_PI_Q30 * 64'(k) + 64'(SINE_TABLE_ENTRIES / 2))
				/ 64'(SINE_TABLE_ENTRIES);
			term = x;
			sum = x;
			for (int j = 1; j <= 8; j++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / 64'((2 * j) * (2 * j + 1));
				if ((j & 1) == 1) begin
					sum = (sum > term) ? sum - term : 64'd0;
				end else begin
					sum = sum + term;
				end
			end
			e = (64'd32767 * sum + Q30_HALF) >> 30;
			if (e > 64'd32767) begin
				e = 64'd32767;
			end
			tab[k] = e[14:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TABLE = build_sine();

endpackage

[sv/gpg_in_if.sv]
// ----------------------------------------------------------------------------
// gpg_in_if: control tick channel.
// Valid/ready channel that carries one stick sample per request.
// ----------------------------------------------------------------------------
interface gpg_in_if import gpg_pkg::*;;
	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/gpg_out_if.sv]
// ----------------------------------------------------------------------------
// gpg_out_if: gait phase result channel.
// Valid/ready channel that carries the phase and the four leg sines.
// ----------------------------------------------------------------------------
interface gpg_out_if import gpg_pkg::*;;
	logic  valid;
	logic  ready;
	gait_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/gait_phase_generator_top.sv]
// ----------------------------------------------------------------------------
// gait_phase_generator_top: gait phase generator.
// Maps stick ticks to a moving decision, advances the gait phase and
// returns the phase with the four leg sines.
//
//   Channel   Dir  Handshake          Content
//   cmd       in   valid/ready        episode_start, stick_present, axes
//   gait      out  valid/ready        phase, sine_leg0..3
//   cfg       in   cfg_wr_en only     cfg_index, cfg_wdata (8 registers)
//
// The front end takes a new request only after it has handed the last one
// to the queue; it steps one shared 30x30 multiplier through five products
// per tick, then hands the tick over and returns to idle to take the next.
// The back end takes a new tick only when its s1 and s2 stages are empty and
// passes it on to the output register. Reset clears phase, hold timer and
// all valid flags, and loads the register defaults. A stalled output holds
// the back end; a two-entry queue lets the front end keep working meanwhile.
// ----------------------------------------------------------------------------
module gait_phase_generator_top import gpg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	gpg_in_if.sink      cmd,
	gpg_out_if.source   gait,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	cfg_t     cfg_q;
	q_entry_t push_data;
	logic     push_valid;
	logic     push_ready;
	q_entry_t pop_data;
	logic     pop_valid;
	logic     pop_ready;

	// Configuration register bank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vx_min <= -16'sd4096;
			cfg_q.vx_max <= 16'sd4096;
			cfg_q.vy_min <= -16'sd4096;
			cfg_q.vy_max <= 16'sd4096;
			cfg_q.wz_min <= -16'sd4096;
			cfg_q.wz_max <= 16'sd4096;
			cfg_q.phase_step <= 16'd2621;
			cfg_q.hold_step <= 15'd655;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_e'(cfg_index))
				CFG_VX_MIN:     cfg_q.vx_min <= signed'(cfg_wdata);
				CFG_VX_MAX:     cfg_q.vx_max <= signed'(cfg_wdata);
				CFG_VY_MIN:     cfg_q.vy_min <= signed'(cfg_wdata);
				CFG_VY_MAX:     cfg_q.vy_max <= signed'(cfg_wdata);
				CFG_WZ_MIN:     cfg_q.wz_min <= signed'(cfg_wdata);
				CFG_WZ_MAX:     cfg_q.wz_max <= signed'(cfg_wdata);
				CFG_PHASE_STEP: cfg_q.phase_step <= cfg_wdata;
				CFG_HOLD_STEP:  cfg_q.hold_step <= cfg_wdata[14:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	// Front end: axis mapping and motion test.
	gpg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// Queue between the two ends.
	gpg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// Back end: timer, phase and sine lookup.
	gpg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.gait      (gait)
	);

	// The front end is busy for the whole mapping sequence after a request.
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("request taken while the front end was still mapping");

	// A request is never taken while a classified tick waits to enter the queue.
	a_no_accept_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |-> !push_valid)
		else $error("request taken during hand-over to the queue");

	// Legs 1 and 2 carry the negated sine of leg 0; leg 3 carries the sine of leg 0.
	a_leg_symmetry: assert property (@(posedge clk) disable iff (!arst_n)
		gait.valid |-> (gait.data.sine_leg1 == -gait.data.sine_leg0)
			&& (gait.data.sine_leg2 == gait.data.sine_leg1)
			&& (gait.data.sine_leg3 == gait.data.sine_leg0))
		else $error("leg sines are not symmetric");

endmodule

[sv/gpg_front.sv]
// ----------------------------------------------------------------------------
// gpg_front: command front end.
// Accepts a tick, maps the three axes to velocity magnitudes and decides
// whether the command is moving, using one shared 30x30 multiplier.
// ----------------------------------------------------------------------------
module gpg_front import gpg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	gpg_in_if.sink   cmd,
	input  cfg_t     cfg,
	output q_entry_t push_data,
	output logic     push_valid,
	input  logic     push_ready
);

	typedef enum logic [2:0] {
		F_IDLE,
		F_MAP_X,
		F_MAP_Y,
		F_MAP_W,
		F_SQ_X,
		F_SQ_Y,
		F_PUSH
	} front_state_t;

	typedef struct packed {
		logic                  neg;
		logic [AXIS_MAG_W-1:0] mag;
	} axis_t;

	front_state_t state_q;

	axis_t            axis_q [3];
	logic             episode_q;
	logic [VEL_W-1:0] vx_q;
	logic [VEL_W-1:0] vy_q;
	logic [VEL_W-1:0] wz_q;
	logic [SQ_W-1:0]  sq_q;
	logic [SQ_W-1:0]  mul_q;
	logic [VEL_W-1:0] op_a;
	logic [VEL_W-1:0] op_b;
	logic [SQ_W:0]    sq_sum;
	logic             accept;

	// Optional negation, then clamping to plus or minus one in Q2.14.
	function automatic axis_t prep_axis(logic signed [15:0] a, logic invert);
		logic signed [16:0] v;
		axis_t              res;
		v = {a[15], a};
		if (invert) begin
			v = -v;
		end
		if (v > 17'sd16384) begin
			v = 17'sd16384;
		end else if (v < -17'sd16384) begin
			v = -17'sd16384;
		end
		res.neg = v[16];
		res.mag = v[16] ? AXIS_MAG_W'(-v) : AXIS_MAG_W'(v);
		return res;
	endfunction

	function automatic logic [15:0] abs16(logic signed [15:0] v);
		return v[15] ? 16'(-v) : 16'(v);
	endfunction

	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);

	// Motion test: squared planar speed or absolute yaw rate against their limits.
	assign sq_sum = {1'b0, sq_q} + {1'b0, mul_q};
	assign push_data.episode_start = episode_q;
	assign push_data.moving = (sq_sum > {1'b0, VEL_SQ_LIMIT}) || (wz_q > WZ_LIMIT);

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			F_MAP_X: begin
				op_a = VEL_W'(axis_q[0].mag);
				op_b = VEL_W'(abs16(axis_q[0].neg ? cfg.vx_min : cfg.vx_max));
			end
			F_MAP_Y: begin
				op_a = VEL_W'(axis_q[1].mag);
				op_b = VEL_W'(abs16(axis_q[1].neg ? cfg.vy_min : cfg.vy_max));
			end
			F_MAP_W: begin
				op_a = VEL_W'(axis_q[2].mag);
				op_b = VEL_W'(abs16(axis_q[2].neg ? cfg.wz_min : cfg.wz_max));
			end
			F_SQ_X: begin
				op_a = vx_q;
				op_b = vx_q;
			end
			F_SQ_Y: begin
				op_a = vy_q;
				op_b = vy_q;
			end
			F_IDLE, F_PUSH: begin
				op_a = '0;
				op_b = '0;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Sequencer: one multiplication per step, then hand over to the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE:  if (accept) state_q <= F_MAP_X;
				F_MAP_X: state_q <= F_MAP_Y;
				F_MAP_Y: state_q <= F_MAP_W;
				F_MAP_W: state_q <= F_SQ_X;
				F_SQ_X:  state_q <= F_SQ_Y;
				F_SQ_Y:  state_q <= F_PUSH;
				F_PUSH:  if (push_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Datapath: captured axes and the results of each multiplier step.
	always_ff @(posedge clk) begin
		if (accept) begin
			episode_q <= cmd.data.episode_start;
			if (cmd.data.stick_present) begin
				axis_q[0] <= prep_axis(cmd.data.left_y, 1'b0);
				axis_q[1] <= prep_axis(cmd.data.left_x, 1'b1);
				axis_q[2] <= prep_axis(cmd.data.right_x, 1'b1);
			end else begin
				axis_q[0] <= '0;
				axis_q[1] <= '0;
				axis_q[2] <= '0;
			end
		end
		if (state_q != F_IDLE && state_q != F_PUSH) begin
			mul_q <= op_a * op_b;
		end
		if (state_q == F_MAP_Y) vx_q <= mul_q[VEL_W-1:0];
		if (state_q == F_MAP_W) vy_q <= mul_q[VEL_W-1:0];
		if (state_q == F_SQ_X)  wz_q <= mul_q[VEL_W-1:0];
		if (state_q == F_SQ_Y)  sq_q <= mul_q;
	end

endmodule

[sv/gpg_queue.sv]
// ----------------------------------------------------------------------------
// gpg_queue: short queue of classified ticks.
// Decouples the command front end from the phase back end.
// ----------------------------------------------------------------------------
module gpg_queue import gpg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_entry_t push_data,
	input  logic     push_valid,
	output logic     push_ready,
	output q_entry_t pop_data,
	output logic     pop_valid,
	input  logic     pop_ready
);

	q_entry_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[sv/gpg_back.sv]
// ----------------------------------------------------------------------------
// gpg_back: phase back end.
// Updates the hold timer and the gait phase for each classified tick, then
// looks up the sine and presents the result in an output register.
// ----------------------------------------------------------------------------
module gpg_back import gpg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  q_entry_t pop_data,
	input  logic     pop_valid,
	output logic     pop_ready,
	gpg_out_if.source gait
);

	logic [15:0] gait_phase_q;
	logic [14:0] hold_timer_q;
	logic        valid_s1;
	logic        valid_s2;
	logic        out_valid_q;
	gait_t       out_data_q;

	logic [SINE_IDX_W-1:0] idx_s2;
	logic [15:0]           phase_s2;

	logic                   do_pop;
	logic                   out_free;
	logic [15:0]            ph0;
	logic [14:0]            ht0;
	logic [14:0]            ht1;
	logic                   active;
	logic                   mid;
	logic [16:0]            ph_sum;
	logic [15:0]            ph_next;
	logic [SINE_PROD_W-1:0] idx_prod;
	logic [1:0]             quad;
	logic [SINE_R_W-1:0]    rem;
	logic [SINE_TBL_W-1:0]  tbl_idx;
	logic [14:0]            tbl_val;
	logic signed [15:0]     s0;

	assign pop_ready = !valid_s1 && !valid_s2;
	assign do_pop = pop_valid && pop_ready;
	assign out_free = !out_valid_q || gait.ready;
	assign gait.valid = out_valid_q;
	assign gait.data = out_data_q;

	// Timer and phase update for the tick at the head of the queue.
	always_comb begin
		ph0 = pop_data.episode_start ? 16'd0 : gait_phase_q;
		ht0 = pop_data.episode_start ? 15'd0 : hold_timer_q;
		if (pop_data.moving) begin
			ht1 = HOLD_RELOAD;
		end else begin
			ht1 = (ht0 > cfg.hold_step) ? ht0 - cfg.hold_step : 15'd0;
		end
		active = pop_data.moving || (ht1 != 15'd0);
		mid = ph0 > MID_CYCLE_LIMIT;
		ph_sum = {1'b0, ph0} + {1'b0, cfg.phase_step};
		if (active || mid) begin
			// A wrap while only finishing the cycle parks the phase at zero.
			ph_next = (ph_sum[16] && !active) ? 16'd0 : ph_sum[15:0];
		end else begin
			ph_next = 16'd0;
		end
	end

	// Table index of the current phase.
	assign idx_prod = SINE_PROD_W'(gait_phase_q) * SINE_PROD_W'(SINE_FOUR_N);

	// Quadrant split, table read and sign.
	always_comb begin
		priority if (idx_s2 >= SINE_IDX_W'(3 * SINE_TABLE_ENTRIES)) begin
			quad = 2'd3;
			rem = SINE_R_W'(idx_s2 - SINE_IDX_W'(3 * SINE_TABLE_ENTRIES));
		end else if (idx_s2 >= SINE_IDX_W'(2 * SINE_TABLE_ENTRIES)) begin
			quad = 2'd2;
			rem = SINE_R_W'(idx_s2 - SINE_IDX_W'(2 * SINE_TABLE_ENTRIES));
		end else if (idx_s2 >= SINE_IDX_W'(SINE_TABLE_ENTRIES)) begin
			quad = 2'd1;
			rem = SINE_R_W'(idx_s2 - SINE_IDX_W'(SINE_TABLE_ENTRIES));
		end else begin
			quad = 2'd0;
			rem = SINE_R_W'(idx_s2);
		end
		tbl_idx = quad[0] ? SINE_TBL_W'(SINE_TABLE_ENTRIES) - SINE_TBL_W'(rem)
			: SINE_TBL_W'(rem);
		tbl_val = SINE_TABLE[tbl_idx];
		s0 = quad[1] ? -signed'({1'b0, tbl_val}) : signed'({1'b0, tbl_val});
	end

	// Control: state registers and stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gait_phase_q <= '0;
			hold_timer_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_pop) begin
				gait_phase_q <= ph_next;
				hold_timer_q <= ht1;
			end
			valid_s1 <= do_pop;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (valid_s2 && out_free) begin
				valid_s2 <= 1'b0;
			end
			if (valid_s2 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (gait.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			idx_s2 <= idx_prod[SINE_PROD_W-1:16];
			phase_s2 <= gait_phase_q;
		end
		if (valid_s2 && out_free) begin
			out_data_q.phase <= phase_s2;
			out_data_q.sine_leg0 <= s0;
			out_data_q.sine_leg1 <= -s0;
			out_data_q.sine_leg2 <= -s0;
			out_data_q.sine_leg3 <= s0;
		end
	end

endmodule
